@@ rtl/des_pkg.sv @@
package des_pkg;

   // field widths
   localparam int VALUE_WIDTH = 10;
   localparam int SUM_WIDTH   = 12;
   localparam int TOTAL_WIDTH = 32;

   // result list limit per value, final result included
   localparam int MAX_RESULTS = 32;
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS);

   // remainder unit bit counter
   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   // stream widths
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = VALUE_WIDTH + SUM_WIDTH + TOTAL_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // saturation limits
   localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = {SUM_WIDTH{1'b1}};
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

   // status of the remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } rem_status_type;

endpackage

@@ rtl/divisor_enumerator_sigma.sv @@
// a value n is handled by trial division over candidates 1..n/2; each divisor found is
// emitted up to the result limit, then a final transaction carries n with the sums
// throughput: one value at a time; the 1-bit-per-cycle remainder unit sets the pace
// req_tready is high only while the sequencer is idle; a full output register stalls it
// reset: synchronous, active high; clears the sequencer, output valid and running total
module divisor_enumerator_sigma
   import des_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // [9:0] value
   input  logic                      req_tlast,   // last_value
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [9:0] divisor, [21:10] divisor_sum,
                                                  // [53:22] list_total
   output logic                      rsp_tlast,   // last_divisor
   output logic                      rsp_tuser    // list_done
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TEST  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   logic                     last_ff, last_in;
   logic [VALUE_WIDTH-1:0]   cand_ff, cand_in;
   logic [SUM_WIDTH-1:0]     sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [TOTAL_WIDTH-1:0]   total_ff, total_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]   rsp_div_ff, rsp_div_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [SUM_WIDTH-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [TOTAL_WIDTH-1:0]   rsp_total_ff, rsp_total_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     rem_start;
   rem_status_type           rem_status;
   logic                     out_free;
   logic [SUM_WIDTH:0]       sum_add;
   logic [SUM_WIDTH-1:0]     sum_sat;
   logic [TOTAL_WIDTH:0]     total_add;
   logic [TOTAL_WIDTH-1:0]   total_sat;

   des_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (cand_ff),
      .status   (rem_status)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // saturating divisor sum: add the candidate, or the value on the final step
   always_comb begin
      if (state_ff == ST_FINAL) begin
         sum_add = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(value_ff);
      end else begin
         sum_add = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(cand_ff);
      end
      sum_sat = sum_add[SUM_WIDTH] ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
   end

   // saturating list total
   assign total_add = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(sum_sat);
   assign total_sat = total_add[TOTAL_WIDTH] ? TOTAL_MAX : total_add[TOTAL_WIDTH-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      cand_in      = cand_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_div_in   = rsp_div_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_total_in = rsp_total_ff;
      rsp_done_in  = rsp_done_ff;
      rem_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata[VALUE_WIDTH-1:0];
               last_in  = req_tlast;
               cand_in  = VALUE_WIDTH'(1);
               sum_in   = '0;
               count_in = '0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (cand_ff <= (value_ff >> 1)) begin
               rem_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               if (rem_status.rem_zero) begin
                  state_in = ST_EMIT;
               end else begin
                  cand_in  = cand_ff + VALUE_WIDTH'(1);
                  state_in = ST_TEST;
               end
            end
         end
         ST_EMIT: begin
            // divisors past the result limit still count in the sum
            if (count_ff >= COUNT_WIDTH'(MAX_RESULTS - 1)) begin
               sum_in   = sum_sat;
               cand_in  = cand_ff + VALUE_WIDTH'(1);
               state_in = ST_TEST;
            end else if (out_free) begin
               sum_in       = sum_sat;
               cand_in      = cand_ff + VALUE_WIDTH'(1);
               count_in     = count_ff + COUNT_WIDTH'(1);
               rsp_valid_in = 1'b1;
               rsp_div_in   = cand_ff;
               rsp_last_in  = 1'b0;
               rsp_sum_in   = '0;
               rsp_total_in = '0;
               rsp_done_in  = 1'b0;
               state_in     = ST_TEST;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               sum_in       = sum_sat;
               total_in     = last_ff ? '0 : total_sat;
               rsp_valid_in = 1'b1;
               rsp_div_in   = value_ff;
               rsp_last_in  = 1'b1;
               rsp_sum_in   = sum_sat;
               rsp_total_in = total_sat;
               rsp_done_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      cand_ff      <= cand_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      rsp_div_ff   <= rsp_div_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_total_ff <= rsp_total_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_total_ff, rsp_sum_ff, rsp_div_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

@@ rtl/des_rem_unit.sv @@
module des_rem_unit
   import des_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output rem_status_type         status
);

   logic [VALUE_WIDTH-1:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [BIT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic [VALUE_WIDTH:0]     trial;
   logic [VALUE_WIDTH:0]     diff;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = BIT_CNT_WIDTH'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - BIT_CNT_WIDTH'(1);
         if (cnt_ff == BIT_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // status is valid on the cycle of the last step
   assign status.done     = busy_ff && (cnt_ff == BIT_CNT_WIDTH'(1));
   assign status.rem_zero = (rem_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

@@ rtl/des_checker.sv @@
module des_checker
   import des_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      req_tlast,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tlast,
   input logic                      rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one value at a time: busy right after a request transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // list done only on a final divisor
   a_done_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("list done on a non-final result");

   // intermediate divisors are nonzero and carry no sum or total
   a_mid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[VALUE_WIDTH-1:0] != '0
         && rsp_tdata[RSP_FIELD_BITS-1:VALUE_WIDTH] == '0)
      else $error("bad intermediate result fields");

   // a waiting intermediate divisor means the value is still in progress
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request ready before the final result");

endmodule

bind divisor_enumerator_sigma des_checker u_des_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import des_pkg::*;

   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_VALUES = 130;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 6000;

   // one expected response transaction
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] divisor;
      logic                   last_divisor;
      logic [SUM_WIDTH-1:0]   divisor_sum;
      logic [TOTAL_WIDTH-1:0] list_total;
      logic                   list_done;
   } divisor_rsp_type;

   // directed row: typed rows carry the final sum and total written out by hand
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
      logic                   typed;
      logic [SUM_WIDTH-1:0]   sum;
      logic [TOTAL_WIDTH-1:0] total;
   } value_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;    // [9:0] value
   logic                      req_tlast;    // last_value
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;    // [9:0] divisor, [21:10] divisor_sum,
                                            // [53:22] list_total
   logic                      rsp_tlast;    // last_divisor
   logic                      rsp_tuser;    // list_done

   divisor_rsp_type        pending_divisors[$];
   logic [TOTAL_WIDTH-1:0] list_total_acc;
   value_row_type          directed_rows [DIRECTED_ROWS];
   int                     errors;
   int                     divisors_checked;
   int                     values_sent;
   int                     lists_sent;
   bit                     no_idle;
   bit                     hold_request;

   divisor_enumerator_sigma i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // trial division over 1..n/2, then n itself with the sums; updates the list total
   function automatic void predict_divisors(input logic [VALUE_WIDTH-1:0] n,
                                            input logic last);
      divisor_rsp_type    item;
      int unsigned        sum;
      int unsigned        d;
      int                 count;
      logic [TOTAL_WIDTH:0] wide_total;
      sum = 0;
      count = 0;
      for (d = 1; d <= n / 2; d++) begin
         if (n % d == 0) begin
            sum = (sum + d > SUM_MAX) ? SUM_MAX : sum + d;
            // divisors beyond the result limit still count in the sum
            if (count < MAX_RESULTS - 1) begin
               item = '0;
               item.divisor = d[VALUE_WIDTH-1:0];
               pending_divisors.insert(pending_divisors.size(), item);
               count++;
            end
         end
      end
      sum = (sum + n > SUM_MAX) ? SUM_MAX : sum + n;
      // saturating list total
      wide_total = {1'b0, list_total_acc} + sum;
      list_total_acc = wide_total[TOTAL_WIDTH] ? TOTAL_MAX : wide_total[TOTAL_WIDTH-1:0];
      item.divisor      = n;
      item.last_divisor = 1'b1;
      item.divisor_sum  = sum[SUM_WIDTH-1:0];
      item.list_total   = list_total_acc;
      item.list_done    = last;
      pending_divisors.insert(pending_divisors.size(), item);
      if (last)
         list_total_acc = '0;
   endfunction

   // offer one value after a random gap and wait for its transaction
   task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_WIDTH - VALUE_WIDTH){1'b0}}, v};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      values_sent++;
      if (last)
         lists_sent++;
   endtask

   // result side back-pressure, with one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      divisor_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_divisors.size() == 0) begin
            errors++;
            $error("unexpected transaction: divisor %0d", rsp_tdata[9:0]);
         end else begin
            want = pending_divisors.pop_front();
            divisors_checked++;
            if (rsp_tdata[9:0] !== want.divisor) begin
               errors++;
               $error("divisor: expected %0d, got %0d", want.divisor, rsp_tdata[9:0]);
            end
            if (rsp_tlast !== want.last_divisor) begin
               errors++;
               $error("last_divisor: expected %0d, got %0d", want.last_divisor, rsp_tlast);
            end
            if (rsp_tdata[21:10] !== want.divisor_sum) begin
               errors++;
               $error("divisor_sum: expected %0d, got %0d", want.divisor_sum,
                      rsp_tdata[21:10]);
            end
            if (rsp_tdata[53:22] !== want.list_total) begin
               errors++;
               $error("list_total: expected %0d, got %0d", want.list_total,
                      rsp_tdata[53:22]);
            end
            if (rsp_tuser !== want.list_done) begin
               errors++;
               $error("list_done: expected %0d, got %0d", want.list_done, rsp_tuser);
            end
         end
      end
   end

   // stimulus
   initial begin
      divisor_rsp_type typed_item;
      int           list_len;
      int           pick;
      int           small_run;
      logic [VALUE_WIDTH-1:0] v;
      logic         last;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      errors = 0;
      divisors_checked = 0;
      values_sent = 0;
      lists_sent = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      list_total_acc = '0;
      small_run = 0;

      // zero and one typed in, extremes, bit patterns, most divisors, largest sigma
      directed_rows = '{
         '{10'd0,    1'b1, 1'b1, 12'd0, 32'd0},
         '{10'd1,    1'b0, 1'b1, 12'd1, 32'd1},
         '{10'd0,    1'b0, 1'b1, 12'd0, 32'd1},
         '{10'd1,    1'b1, 1'b1, 12'd1, 32'd2},
         '{10'd2,    1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd3,    1'b1, 1'b0, 12'd0, 32'd0},
         '{10'd1023, 1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd512,  1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd511,  1'b1, 1'b0, 12'd0, 32'd0},
         '{10'd341,  1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd682,  1'b1, 1'b0, 12'd0, 32'd0},
         '{10'd840,  1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd720,  1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd1008, 1'b1, 1'b0, 12'd0, 32'd0},
         '{10'd997,  1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd6,    1'b1, 1'b0, 12'd0, 32'd0},
         '{10'd0,    1'b1, 1'b1, 12'd0, 32'd0},
         '{10'd1,    1'b1, 1'b1, 12'd1, 32'd1},
         '{10'd4,    1'b0, 1'b0, 12'd0, 32'd0},
         '{10'd28,   1'b1, 1'b0, 12'd0, 32'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].last);
         predict_divisors(directed_rows[i].value, directed_rows[i].last);
         if (directed_rows[i].typed) begin
            // zero and one give a single transaction, taken from the table
            typed_item.divisor      = directed_rows[i].value;
            typed_item.last_divisor = 1'b1;
            typed_item.divisor_sum  = directed_rows[i].sum;
            typed_item.list_total   = directed_rows[i].total;
            typed_item.list_done    = directed_rows[i].last;
            pending_divisors[pending_divisors.size() - 1] = typed_item;
         end
      end

      // sender pause until everything has drained
      req_tvalid <= 1'b0;
      while (pending_divisors.size() != 0) @(posedge clock);

      // random lists, mostly small values to keep the trial loop short
      while (values_sent < DIRECTED_ROWS + RANDOM_VALUES) begin
         list_len = $urandom_range(1, 6);
         no_idle = ($urandom_range(0, 3) == 0);
         if (hold_request == 1'b0 && values_sent >= DIRECTED_ROWS + 30 && small_run == 0
             && values_sent < DIRECTED_ROWS + 40) begin
            // long receiver hold-off while short values keep coming
            hold_request = 1'b1;
            small_run = 12;
         end
         if (values_sent >= DIRECTED_ROWS + 90 && values_sent < DIRECTED_ROWS + 97) begin
            req_tvalid <= 1'b0;
            while (pending_divisors.size() != 0) @(posedge clock);
         end
         for (int k = 0; k < list_len; k++) begin
            pick = $urandom_range(0, 9);
            if (small_run > 0) begin
               v = VALUE_WIDTH'($urandom_range(1, 15));
               small_run--;
            end else if (pick <= 5)
               v = VALUE_WIDTH'($urandom_range(0, 63));
            else if (pick <= 7)
               v = VALUE_WIDTH'($urandom_range(64, 255));
            else if (pick == 8)
               v = VALUE_WIDTH'($urandom_range(256, 1023));
            else
               v = ($urandom_range(0, 1) == 1) ? 10'd840 : 10'd960;
            last = (k == list_len - 1);
            send_value(v, last);
            predict_divisors(v, last);
         end
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      // drain and watch for stray transactions
      while (pending_divisors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d values in %0d lists, %0d divisor transactions checked",
               values_sent, lists_sent, divisors_checked);
      $display("zero, one, 1023 and 840 included, with a long result stall and a full drain");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // overall time limit
   initial begin
      #(40_000_000);
      $display("timeout with %0d transactions outstanding", pending_divisors.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
